### rtl/aes_cbc_cipher_defines.svh
// Assertion macros shared by the AES-CBC RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef AES_CBC_CIPHER_DEFINES_SVH
`define AES_CBC_CIPHER_DEFINES_SVH

// Same-cycle implication.
`define AST_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/aes_cbc_pkg.sv
// Shared types, tables and GF(2^8) helpers for the AES-CBC block.
// No dependencies.
package aes_cbc_pkg;

  typedef logic [7:0] sbox_tab_t [256];

  localparam sbox_tab_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Inverse table built at elaboration from the forward one
  function automatic sbox_tab_t gen_inv_sbox();
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam sbox_tab_t INV_SBOX = gen_inv_sbox();

  localparam int NUM_ROWS = 15;  // round-key rows of four words
  localparam int ROW_AW   = 4;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY_LEN = 3'd0, REG_DECRYPT = 3'd1, REG_KEY0 = 3'd2, REG_KEY1 = 3'd3,
    REG_KEY2    = 3'd4, REG_KEY3    = 3'd5, REG_IV_HI = 3'd6, REG_IV_LO = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXPAND, S_PREP, S_CIPH, S_FIN
  } state_t;

  // Per-step controls for the round unit
  typedef struct packed {
    logic dec;
    logic first;
    logic last;
  } round_ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // One column of MixColumns or its inverse; row 0 in bits 31:24
  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] r;
    for (int k = 0; k < 4; k++) begin
      a[k]  = col[31-8*k -: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m2[k] = x2[k];
      m3[k] = x2[k] ^ a[k];
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    for (int k = 0; k < 4; k++) begin
      if (inv) begin
        r[31-8*k -: 8] = me[k] ^ mb[(k+1)%4] ^ md[(k+2)%4] ^ m9[(k+3)%4];
      end else begin
        r[31-8*k -: 8] = m2[k] ^ m3[(k+1)%4] ^ a[(k+2)%4] ^ a[(k+3)%4];
      end
    end
    return r;
  endfunction

endpackage

### rtl/aes_cbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aes_cbc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/aes_cbc_round.sv
// Shared AES round unit: one forward or inverse round, or the key whitening step.
// Depends on aes_cbc_pkg.
module aes_cbc_round (
  input  logic [127:0]             st_in,
  input  logic [127:0]             rkey,
  input  aes_cbc_pkg::round_ctl_t  ctl,
  output logic [127:0]             st_out
);
  import aes_cbc_pkg::*;

  logic [127:0] sr_f;
  logic [127:0] sub_f;
  logic [127:0] mix_f;
  logic [127:0] sr_i;
  logic [127:0] sub_i;
  logic [127:0] ark_i;
  logic [127:0] mix_i;

  // Forward: SubBytes, ShiftRows, MixColumns
  always_comb begin
    for (int n = 0; n < 16; n++) begin
      sub_f[127-8*n -: 8] = SBOX[st_in[127-8*n -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr_f[127-8*(r+4*c) -: 8] = sub_f[127-8*(r+4*((c+r)%4)) -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      mix_f[127-32*c -: 32] = mix_col(sr_f[127-32*c -: 32], 1'b0);
    end
  end

  // Inverse: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr_i[127-8*(r+4*((c+r)%4)) -: 8] = st_in[127-8*(r+4*c) -: 8];
      end
    end
    for (int n = 0; n < 16; n++) begin
      sub_i[127-8*n -: 8] = INV_SBOX[sr_i[127-8*n -: 8]];
    end
    ark_i = sub_i ^ rkey;
    for (int c = 0; c < 4; c++) begin
      mix_i[127-32*c -: 32] = mix_col(ark_i[127-32*c -: 32], 1'b1);
    end
  end

  always_comb begin
    if (ctl.first) begin
      st_out = st_in ^ rkey;
    end else if (ctl.dec) begin
      st_out = ctl.last ? ark_i : mix_i;
    end else begin
      st_out = (ctl.last ? sr_f : mix_f) ^ rkey;
    end
  end
endmodule

### rtl/aes_cbc_keyexp.sv
// AES key schedule: one round-key word a cycle while run is high, packed into rows of four.
// Depends on aes_cbc_pkg.
module aes_cbc_keyexp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         run,
  input  logic [3:0]                   nk,
  input  logic [255:0]                 key,
  output logic                         row_we,
  output logic [aes_cbc_pkg::ROW_AW-1:0] row_addr,
  output logic [127:0]                 row_data,
  output logic                         last_word
);
  import aes_cbc_pkg::*;

  logic [5:0]  idx_r;
  logic [2:0]  phase_r;
  logic [7:0]  rcon_r;
  logic [31:0] win_r [8];
  logic [31:0] temp;
  logic [31:0] word;
  logic [3:0]  nr;

  assign nr        = nk + 4'd6;
  assign last_word = run && (idx_r[5:2] == nr) && (idx_r[1:0] == 2'd3);

  // Next schedule word
  always_comb begin
    if (phase_r == 3'd0) begin
      temp = sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rcon_r, 24'h0};
    end else if ((nk == 4'd8) && (phase_r == 3'd4)) begin
      temp = sub_word(win_r[0]);
    end else begin
      temp = win_r[0];
    end
    if (idx_r < 6'(nk)) begin
      word = key[255-32*idx_r[2:0] -: 32];
    end else begin
      word = win_r[3'(nk - 4'd1)] ^ temp;
    end
  end

  assign row_we   = run && (idx_r[1:0] == 2'd3);
  assign row_addr = idx_r[5:2];
  assign row_data = {win_r[2], win_r[1], win_r[0], word};

  // Word counter, position within nk and round constant
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      phase_r <= '0;
      rcon_r  <= 8'h01;
    end else if (start) begin
      idx_r   <= '0;
      phase_r <= '0;
      rcon_r  <= 8'h01;
    end else if (run) begin
      idx_r   <= idx_r + 6'd1;
      phase_r <= (phase_r == 3'(nk - 4'd1)) ? 3'd0 : phase_r + 3'd1;
      if ((phase_r == 3'd0) && (idx_r >= 6'(nk))) begin
        rcon_r <= xtime(rcon_r);
      end
    end
  end

  // Window of the last eight words
  always_ff @(posedge clk) begin
    if (run) begin
      win_r[0] <= word;
      for (int k = 1; k < 8; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end
endmodule

### rtl/aes_cbc_cipher.sv
// Top level of the AES-CBC cipher: sequencer, chaining, ports.
// Depends on aes_cbc_pkg, aes_cbc_ram, aes_cbc_keyexp, aes_cbc_round, defines header.
//
//  channel | dir | contents
//  in_*    | in  | tdata {block_low, block_high}, tuser chain_start
//  out_*   | out | tdata {out_low, out_high}
//  cfg_*   | in  | register write, index 0..7
//
// After its item is taken, a result passes a prep state with the key-row read,
// Nr+1 steps of the shared round unit and a result write, which waits while the
// output register holds an unaccepted result. The next item is taken in idle.
// A chain start (or the first block after reset) first adds a pass of key
// expansion. Reset is synchronous, active low; no clearing pass.
// A new item is taken while a result waits in the output register; a stalled
// output holds the next result.
`include "aes_cbc_cipher_defines.svh"
module aes_cbc_cipher (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // block_high [63:0], block_low [127:64]
  input  logic         in_tuser,   // chain_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // out_high [63:0], out_low [127:64]
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata
);
  import aes_cbc_pkg::*;

  logic [1:0]   key_len_r;
  logic         decrypt_r;
  logic [255:0] key_r;
  logic [127:0] iv_r;

  state_t       state_r;
  state_t       state_nxt;
  logic         keys_valid_r;
  logic [3:0]   nk_r;
  logic [3:0]   nr_r;
  logic [3:0]   step_r;
  logic [127:0] blk_r;
  logic [127:0] st_r;
  logic [127:0] chain_r;
  logic         out_valid_r;
  logic [127:0] out_data_r;

  logic              accept;
  logic              need_keys;
  logic              kx_start;
  logic              kx_run;
  logic              kx_last;
  logic              row_we;
  logic [ROW_AW-1:0] row_waddr;
  logic [127:0]      row_wdata;
  logic [ROW_AW-1:0] row_raddr;
  logic [127:0]      rkey;
  logic [3:0]        rd_step;
  round_ctl_t        rctl;
  logic [127:0]      rnd_out;
  logic              fin_fire;
  logic [3:0]        nk_new;

  assign accept    = in_tvalid && in_tready;
  assign need_keys = in_tuser || !keys_valid_r;
  assign fin_fire  = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign nk_new    = key_len_r[1] ? 4'd8 : (key_len_r[0] ? 4'd6 : 4'd4);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
      decrypt_r <= 1'b0;
      key_r     <= '0;
      iv_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_KEY_LEN: key_len_r          <= cfg_wdata[1:0];
        REG_DECRYPT: decrypt_r          <= cfg_wdata[0];
        REG_KEY0:    key_r[255:192]     <= cfg_wdata;
        REG_KEY1:    key_r[191:128]     <= cfg_wdata;
        REG_KEY2:    key_r[127:64]      <= cfg_wdata;
        REG_KEY3:    key_r[63:0]        <= cfg_wdata;
        REG_IV_HI:   iv_r[127:64]       <= cfg_wdata;
        REG_IV_LO:   iv_r[63:0]         <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = need_keys ? S_EXPAND : S_PREP;
      S_EXPAND: if (kx_last) state_nxt = S_PREP;
      S_PREP:   state_nxt = S_CIPH;
      S_CIPH:   if (step_r == nr_r) state_nxt = S_FIN;
      S_FIN:    if (fin_fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready = 1'b0;
    kx_run    = 1'b0;
    rd_step   = '0;
    case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_EXPAND: kx_run = 1'b1;
      S_PREP:   rd_step = '0;
      S_CIPH:   rd_step = (step_r == nr_r) ? step_r : step_r + 4'd1;
      S_FIN:    in_tready = 1'b0;
      default:  in_tready = 1'b0;
    endcase
  end

  assign kx_start  = accept && need_keys;
  assign row_raddr = decrypt_r ? (nr_r - rd_step) : rd_step;
  assign rctl.dec   = decrypt_r;
  assign rctl.first = (step_r == 4'd0);
  assign rctl.last  = (step_r == nr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      keys_valid_r <= 1'b0;
      nk_r         <= 4'd4;
      nr_r         <= 4'd10;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
      chain_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (kx_start) begin
        nk_r <= nk_new;
        nr_r <= nk_new + 4'd6;
      end
      if (kx_last) begin
        keys_valid_r <= 1'b1;
        chain_r      <= iv_r;
      end
      if (state_r == S_PREP) begin
        step_r <= '0;
      end else if ((state_r == S_CIPH) && (step_r != nr_r)) begin
        step_r <= step_r + 4'd1;
      end
      if (fin_fire) begin
        out_valid_r <= 1'b1;
        chain_r     <= decrypt_r ? blk_r : st_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Data path registers
  always_ff @(posedge clk) begin
    if (accept) begin
      blk_r <= {in_tdata[63:0], in_tdata[127:64]};
    end
    if (state_r == S_PREP) begin
      st_r <= decrypt_r ? blk_r : (blk_r ^ chain_r);
    end else if (state_r == S_CIPH) begin
      st_r <= rnd_out;
    end
    if (fin_fire) begin
      out_data_r <= decrypt_r ? (st_r ^ chain_r) : st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r[63:0], out_data_r[127:64]};

  aes_cbc_keyexp u_keyexp (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (kx_start),
    .run       (kx_run),
    .nk        (nk_r),
    .key       (key_r),
    .row_we    (row_we),
    .row_addr  (row_waddr),
    .row_data  (row_wdata),
    .last_word (kx_last)
  );

  aes_cbc_ram #(.WIDTH(128), .DEPTH(NUM_ROWS)) u_rk_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (rkey)
  );

  aes_cbc_round u_round (
    .st_in  (st_r),
    .rkey   (rkey),
    .ctl    (rctl),
    .st_out (rnd_out)
  );

  `AST_IMPL(a_ready_idle, in_tready, !out_valid_r || state_r == S_IDLE)
  `AST_NEXT(a_accept_busy, accept, !in_tready)
  `AST_IMPL(a_keys_before_cipher, state_r == S_PREP, keys_valid_r)
  `AST_IMPL(a_rows_in_expand, row_we, state_r == S_EXPAND)
  `AST_NEXT(a_last_round_fin, state_r == S_CIPH && step_r == nr_r, state_r == S_FIN)
endmodule
